/* hw/rtl/dalf_pkg.sv */
// Shared types and constants for the duty-cycle ASCII line formatter.
`timescale 1ns / 1ps
`default_nettype none

package dalf_pkg;

    // Field widths.
    localparam int DUTY_W = 18;
    localparam int BYTE_W = 8;
    localparam int SCALE_W = 17;
    localparam int PROD_W = DUTY_W + SCALE_W;
    localparam int MAG_W = 17;
    localparam int NUM_DIGITS = 6;
    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int DIG_IDX_W = 3;
    localparam int NDIG_W = 3;

    // Scaling and saturation.
    localparam logic [SCALE_W-1:0] SCALE = 17'd100000;
    localparam logic [MAG_W-1:0] LIMIT = 17'd100000;

    // ASCII characters of the line.
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;

    // Byte selection codes for the output register.
    localparam logic [1:0] SEL_SIGN = 2'd0;
    localparam logic [1:0] SEL_DIGIT = 2'd1;
    localparam logic [1:0] SEL_CR = 2'd2;
    localparam logic [1:0] SEL_LF = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load_in;
        logic                 mul_en;
        logic                 scale_en;
        logic                 conv_step;
        logic                 emit_load;
        logic [1:0]           emit_sel;
        logic [DIG_IDX_W-1:0] digit_idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              neg;
        logic [NDIG_W-1:0] ndig;
        logic              out_free;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/dalf_dp.sv */
// Datapath: magnitude, scaling multiply, saturation, binary to BCD and output register.
`timescale 1ns / 1ps
`default_nettype none

module dalf_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire logic signed [dalf_pkg::DUTY_W-1:0] duty,
    input  wire dalf_pkg::cmd_t                 cmd,
    output dalf_pkg::status_t                   st,
    input  wire                                 out_stall,
    output logic                                out_valid,
    output logic [dalf_pkg::BYTE_W-1:0]         text_byte,
    output logic                                last_byte
);

    logic [dalf_pkg::DUTY_W-1:0] mag_in_reg;
    logic [dalf_pkg::DUTY_W-1:0] mag_in_next;
    logic                        neg_reg;
    logic [dalf_pkg::PROD_W-1:0] prod_reg;
    logic [dalf_pkg::PROD_W-1:0] shifted;
    logic [dalf_pkg::MAG_W-1:0]  sat_mag;
    logic [dalf_pkg::MAG_W-1:0]  bin_reg;
    logic [dalf_pkg::BCD_W-1:0]  bcd_reg;
    logic [dalf_pkg::BCD_W-1:0]  bcd_adj;
    logic [3:0]                  digit;
    logic [dalf_pkg::BYTE_W-1:0] byte_next;
    logic [dalf_pkg::BYTE_W-1:0] text_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [dalf_pkg::NDIG_W-1:0] ndig;

    // Magnitude of the two's complement input.
    always_comb
    begin
        if (duty[dalf_pkg::DUTY_W-1])
        begin
            mag_in_next = dalf_pkg::DUTY_W'(0) - $unsigned(duty);
        end
        else
        begin
            mag_in_next = $unsigned(duty);
        end
    end

    // Truncate the product toward zero and saturate the magnitude.
    always_comb
    begin
        shifted = prod_reg >> FRAC_BITS;
        if (shifted > dalf_pkg::PROD_W'(dalf_pkg::LIMIT))
        begin
            sat_mag = dalf_pkg::LIMIT;
        end
        else
        begin
            sat_mag = shifted[dalf_pkg::MAG_W-1:0];
        end
    end

    // Add-three correction of every BCD digit before each shift.
    always_comb
    begin
        for (int i = 0; i < dalf_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Input capture, multiply, scale and conversion registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mag_in_reg <= mag_in_next;
            neg_reg    <= duty[dalf_pkg::DUTY_W-1];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= dalf_pkg::PROD_W'(mag_in_reg) * dalf_pkg::PROD_W'(dalf_pkg::SCALE);
        end
        if (cmd.scale_en)
        begin
            bin_reg <= sat_mag;
            bcd_reg <= '0;
            neg_reg <= neg_reg && (sat_mag != '0);
        end
        else if (cmd.conv_step)
        begin
            bin_reg <= {bin_reg[dalf_pkg::MAG_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[dalf_pkg::BCD_W-2:0], bin_reg[dalf_pkg::MAG_W-1]};
        end
    end

    // Number of significant digits, at least one.
    always_comb
    begin
        if (bcd_reg[23:20] != 4'd0)
        begin
            ndig = 3'd6;
        end
        else if (bcd_reg[19:16] != 4'd0)
        begin
            ndig = 3'd5;
        end
        else if (bcd_reg[15:12] != 4'd0)
        begin
            ndig = 3'd4;
        end
        else if (bcd_reg[11:8] != 4'd0)
        begin
            ndig = 3'd3;
        end
        else if (bcd_reg[7:4] != 4'd0)
        begin
            ndig = 3'd2;
        end
        else
        begin
            ndig = 3'd1;
        end
    end

    // Digit picked by the controller.
    always_comb
    begin
        case (cmd.digit_idx)
            3'd0:    digit = bcd_reg[3:0];
            3'd1:    digit = bcd_reg[7:4];
            3'd2:    digit = bcd_reg[11:8];
            3'd3:    digit = bcd_reg[15:12];
            3'd4:    digit = bcd_reg[19:16];
            3'd5:    digit = bcd_reg[23:20];
            default: digit = 4'd0;
        endcase
    end

    // Character for the output register.
    always_comb
    begin
        unique case (cmd.emit_sel)
            dalf_pkg::SEL_SIGN:  byte_next = dalf_pkg::ASCII_MINUS;
            dalf_pkg::SEL_DIGIT: byte_next = dalf_pkg::ASCII_ZERO + {4'd0, digit};
            dalf_pkg::SEL_CR:    byte_next = dalf_pkg::ASCII_CR;
            dalf_pkg::SEL_LF:    byte_next = dalf_pkg::ASCII_LF;
            default:             byte_next = dalf_pkg::ASCII_LF;
        endcase
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            text_reg <= byte_next;
            last_reg <= (cmd.emit_sel == dalf_pkg::SEL_LF);
        end
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign text_byte   = text_reg;
    assign last_byte   = last_reg;
    assign st.neg      = neg_reg;
    assign st.ndig     = ndig;
    assign st.out_free = !out_valid_reg || !out_stall;

    // Every BCD digit stays a decimal digit through the conversion.
    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv_step |=> (bcd_reg[3:0] <= 4'd9) && (bcd_reg[7:4] <= 4'd9) &&
            (bcd_reg[11:8] <= 4'd9) && (bcd_reg[15:12] <= 4'd9) &&
            (bcd_reg[19:16] <= 4'd9) && (bcd_reg[23:20] <= 4'd1))
        else $error("BCD digit out of range during conversion");

endmodule

`default_nettype wire

/* hw/rtl/dalf_ctrl.sv */
// Controller: sequences capture, multiply, conversion and byte emission of one item.
`timescale 1ns / 1ps
`default_nettype none

module dalf_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire dalf_pkg::status_t  st,
    output dalf_pkg::cmd_t          cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SCALE = 4'd2;
    localparam logic [3:0] S_CONV  = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_SIGN  = 4'd5;
    localparam logic [3:0] S_DIGIT = 4'd6;
    localparam logic [3:0] S_CR    = 4'd7;
    localparam logic [3:0] S_LF    = 4'd8;

    localparam int CNT_W = $clog2(dalf_pkg::MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dalf_pkg::MAG_W - 1);

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [dalf_pkg::DIG_IDX_W-1:0] idx_reg;
    logic [dalf_pkg::DIG_IDX_W-1:0] idx_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.digit_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_en = 1'b1;
                cnt_next     = '0;
                state_next   = S_CONV;
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                idx_next   = st.ndig - dalf_pkg::NDIG_W'(1);
                state_next = st.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = dalf_pkg::SEL_SIGN;
                    state_next    = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = dalf_pkg::SEL_DIGIT;
                    if (idx_reg == '0)
                    begin
                        state_next = S_CR;
                    end
                    else
                    begin
                        idx_next = idx_reg - dalf_pkg::DIG_IDX_W'(1);
                    end
                end
            end
            S_CR:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = dalf_pkg::SEL_CR;
                    state_next    = S_LF;
                end
            end
            S_LF:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = dalf_pkg::SEL_LF;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, bit counter and digit index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // A byte is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> st.out_free)
        else $error("Output register overwritten while stalled");

    // The conversion runs for exactly one step per magnitude bit.
    a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |=> ##(dalf_pkg::MAG_W) (state_reg == S_PREP))
        else $error("Binary to BCD conversion length wrong");

    // The digit index stays inside the digit register.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |-> (idx_reg < dalf_pkg::DIG_IDX_W'(dalf_pkg::NUM_DIGITS)))
        else $error("Digit index out of range");

    // Once the LF is loaded, the controller is ready for the next item.
    a_lf_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && (cmd.emit_sel == dalf_pkg::SEL_LF)) |=> (state_reg == S_IDLE))
        else $error("Line end did not return to idle");

endmodule

`default_nettype wire

/* hw/rtl/duty_to_ascii_line_formatter.sv */
// Top level of the duty-cycle ASCII line formatter: controller and datapath.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  input   | in        | in_valid / in_stall | duty (18 bit signed, Q2.FRAC_BITS)
//  output  | out       | out_valid/out_stall | text_byte (8 bit), last_byte (1 bit)
//
// One item is captured, multiplied, scaled and saturated, converted to BCD one
// magnitude bit per cycle, given a step to pick the first digit, and then sent as
// 3 to 9 bytes, one per cycle while the output is not stalled. The BCD conversion
// loop takes the largest share of the time of each item.
// Reset is asynchronous, active low, and empties the output register.
// A stall on the output holds the byte in place and delays the rest of the line;
// the next item is taken as soon as the LF sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module duty_to_ascii_line_formatter #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire logic signed [dalf_pkg::DUTY_W-1:0] duty,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [dalf_pkg::BYTE_W-1:0]         text_byte,
    output logic                                last_byte
);

    dalf_pkg::cmd_t    cmd;
    dalf_pkg::status_t st;

    // Sequencing of one item.
    dalf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Arithmetic, conversion and output register.
    dalf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .duty      (duty),
        .cmd       (cmd),
        .st        (st),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .text_byte (text_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the duty-cycle ASCII line formatter.
`timescale 1ns / 1ps

module tb_top;

    localparam int DUTY_FRAC = 16;
    localparam int FULL_SCALE = 100000;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    // One expected byte of an output line.
    typedef struct packed {
        logic [dalf_pkg::BYTE_W-1:0] ch;
        logic                        last;
    } line_byte_t;

    // Directed stimulus: an empty text means the predictor supplies the line.
    typedef struct {
        int    duty;
        string text;
    } duty_row_t;

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic signed [dalf_pkg::DUTY_W-1:0] duty = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [dalf_pkg::BYTE_W-1:0]        text_byte;
    logic                               last_byte;

    line_byte_t line_q[$];
    int         mismatches = 0;
    bit         hold_req = 1'b0;

    duty_row_t duty_rows [22] = '{
        '{0, "0"},
        '{65536, "100000"},
        '{-65536, "-100000"},
        '{131071, "100000"},
        '{-131072, "-100000"},
        '{32768, "50000"},
        '{-32768, "-50000"},
        '{1, ""},
        '{-1, ""},
        '{65535, ""},
        '{-65535, ""},
        '{65537, ""},
        '{-65537, ""},
        '{98304, ""},
        '{6554, ""},
        '{655, ""},
        '{656, ""},
        '{6, ""},
        '{7, ""},
        '{-66, ""},
        '{-2, ""},
        '{0, "0"}
    };

    duty_to_ascii_line_formatter #(
        .FRAC_BITS(DUTY_FRAC)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .duty(duty),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .text_byte(text_byte),
        .last_byte(last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #8_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Scale a Q2.16 duty to percent times 1000, truncated toward zero and saturated.
    function automatic int scaled_duty(input logic signed [dalf_pkg::DUTY_W-1:0] d);
        longint mag;
        longint prod;
        mag = (d < 0) ? -longint'(d) : longint'(d);
        prod = (mag * FULL_SCALE) >>> DUTY_FRAC;
        if (prod > FULL_SCALE)
        begin
            prod = FULL_SCALE;
        end
        return (d < 0) ? -int'(prod) : int'(prod);
    endfunction

    task automatic note_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one item and, once it is taken, queue the line it should produce.
    task automatic offer_duty(input logic signed [dalf_pkg::DUTY_W-1:0] d,
                              input string typed_text);
        string line;
        int    i;
        @(negedge clk);
        in_valid <= 1'b1;
        duty <= d;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        line = (typed_text.len() != 0) ? typed_text : $sformatf("%0d", scaled_duty(d));
        for (i = 0; i < line.len(); i++)
        begin
            line_q.push_back('{line[i], 1'b0});
        end
        line_q.push_back('{dalf_pkg::ASCII_CR, 1'b0});
        line_q.push_back('{dalf_pkg::ASCII_LF, 1'b1});
    endtask

    // Leave the input idle for a number of cycles after an accepted item.
    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            duty <= dalf_pkg::DUTY_W'($urandom);
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Random duty with weight on saturation edges and short lines.
    function automatic logic signed [dalf_pkg::DUTY_W-1:0] random_duty();
        logic signed [dalf_pkg::DUTY_W-1:0] d;
        int                                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            d = dalf_pkg::DUTY_W'($urandom_range(0, (1 << dalf_pkg::DUTY_W) - 1));
        end
        else if (pick < 7)
        begin
            d = dalf_pkg::DUTY_W'(65516 + $urandom_range(0, 40));
        end
        else if (pick < 9)
        begin
            d = dalf_pkg::DUTY_W'($urandom_range(0, 700));
        end
        else
        begin
            d = dalf_pkg::DUTY_W'($urandom_range(0, 65536));
        end
        if (pick >= 5 && $urandom_range(0, 1) == 1)
        begin
            d = -d;
        end
        return d;
    endfunction

    // Receiver stall pattern, with a long hold-off on request.
    initial
    begin : rx_stall_gen
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       beat;
        mode = RX_FREE;
        mode_left = 100;
        hold_left = 0;
        beat = 0;
        forever
        begin
            @(negedge clk);
            beat++;
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default:  out_stall <= (beat % 3 == 0);
                endcase
            end
        end
    end

    // Compare each accepted output byte with the oldest expected one.
    always @(posedge clk)
    begin
        line_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_q.size() == 0)
            begin
                note_mismatch($sformatf("unexpected byte %02h last %0b", text_byte, last_byte));
            end
            else
            begin
                want = line_q.pop_front();
                if (text_byte !== want.ch)
                begin
                    note_mismatch($sformatf("text_byte %02h, want %02h", text_byte, want.ch));
                end
                if (last_byte !== want.last)
                begin
                    note_mismatch($sformatf("last_byte %0b, want %0b", last_byte, want.last));
                end
            end
        end
    end

    // Main sequence: reset, directed rows, random bursts, drain.
    initial
    begin
        int n;
        int burst_left;
        int tail;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (duty_rows[r])
        begin
            offer_duty(dalf_pkg::DUTY_W'(duty_rows[r].duty), duty_rows[r].text);
            idle_input($urandom_range(0, 2));
        end

        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                hold_req = 1'b1;
            end
            offer_duty(random_duty(), "");
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            end
            else
            begin
                burst_left--;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (line_q.size() != 0)
        begin
            @(posedge clk);
        end
        for (tail = 0; tail < TAIL_CYCLES; tail++)
        begin
            @(posedge clk);
        end

        if (mismatches == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
